// File: hdl/hfm_pkg.sv
// Shared types, codes and helpers of the heightfield triangle mesher.
`timescale 1ns / 1ps
package hfm_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_CROSS,
    ST_SQ,
    ST_RT,
    ST_DV,
    ST_EMIT
  } state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD,
    OP_CROSS,
    OP_SQ,
    OP_RT,
    OP_DV,
    OP_EMIT
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       half;
    logic [5:0] step;
  } cmd_t;

  typedef struct packed {
    logic has_result;
    logic out_free;
  } sts_t;

  localparam logic [1:0] CFG_ROW_LENGTH  = 2'd0;
  localparam logic [1:0] CFG_ROW_COUNT   = 2'd1;
  localparam logic [1:0] CFG_CELL_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_CELL_HEIGHT = 2'd3;

  localparam logic [5:0] SQ_LAST = 6'd8;
  localparam logic [5:0] RT_LAST = 6'd40;
  localparam logic [5:0] DV_LAST = 6'd47;

  localparam logic [81:0] RT_TOP = 82'(1) << 80;

  // Turn a magnitude quotient into a saturated Q1.15 component.
  function automatic logic [15:0] finish_comp(logic [15:0] q, logic neg, logic zero);
    logic [15:0] r;
    if (zero) begin
      r = 16'd0;
    end else if (neg) begin
      r = ~q + 16'd1;
    end else if (q[15]) begin
      r = 16'h7FFF;
    end else begin
      r = q;
    end
    return r;
  endfunction

endpackage

// File: hdl/hfm_ctrl.sv
// Sequencing state machine of the heightfield triangle mesher.
`timescale 1ns / 1ps
module hfm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  hfm_pkg::sts_t sts_i,
  output hfm_pkg::cmd_t cmd_o
);

  hfm_pkg::state_e state_q, state_d;
  logic [5:0]      step_q, step_d;
  logic            half_q, half_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hfm_pkg::ST_IDLE;
      step_q  <= 6'd0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      half_q  <= half_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    half_d  = half_q;
    unique case (state_q)
      hfm_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = hfm_pkg::ST_LOAD;
      end
      hfm_pkg::ST_LOAD: begin
        half_d  = 1'b0;
        state_d = sts_i.has_result ? hfm_pkg::ST_CROSS : hfm_pkg::ST_IDLE;
      end
      hfm_pkg::ST_CROSS: begin
        state_d = hfm_pkg::ST_SQ;
        step_d  = 6'd0;
      end
      hfm_pkg::ST_SQ: begin
        if (step_q == hfm_pkg::SQ_LAST) begin
          state_d = hfm_pkg::ST_RT;
          step_d  = 6'd0;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      hfm_pkg::ST_RT: begin
        if (step_q == hfm_pkg::RT_LAST) begin
          state_d = hfm_pkg::ST_DV;
          step_d  = 6'd0;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      hfm_pkg::ST_DV: begin
        if (step_q == hfm_pkg::DV_LAST) begin
          state_d = hfm_pkg::ST_EMIT;
        end else begin
          step_d = step_q + 6'd1;
        end
      end
      hfm_pkg::ST_EMIT: begin
        if (sts_i.out_free) begin
          if (!half_q) begin
            half_d  = 1'b1;
            state_d = hfm_pkg::ST_CROSS;
          end else begin
            state_d = hfm_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = hfm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op   = hfm_pkg::OP_NONE;
    cmd_o.half = half_q;
    cmd_o.step = step_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      hfm_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) cmd_o.op = hfm_pkg::OP_ACCEPT;
      end
      hfm_pkg::ST_LOAD:  cmd_o.op = hfm_pkg::OP_LOAD;
      hfm_pkg::ST_CROSS: cmd_o.op = hfm_pkg::OP_CROSS;
      hfm_pkg::ST_SQ:    cmd_o.op = hfm_pkg::OP_SQ;
      hfm_pkg::ST_RT:    cmd_o.op = hfm_pkg::OP_RT;
      hfm_pkg::ST_DV:    cmd_o.op = hfm_pkg::OP_DV;
      hfm_pkg::ST_EMIT: begin
        if (sts_i.out_free) cmd_o.op = hfm_pkg::OP_EMIT;
      end
      default: cmd_o.op = hfm_pkg::OP_NONE;
    endcase
  end

endmodule

// File: hdl/hfm_dp.sv
// Datapath of the heightfield triangle mesher: line store, geometry, normal unit.
`timescale 1ns / 1ps
module hfm_dp #(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int MAX_ROW_COUNT  = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hfm_pkg::cmd_t      cmd_i,
  output hfm_pkg::sts_t      sts_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic signed [23:0] height_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [25:0]        x_left_o,
  output logic [25:0]        x_right_o,
  output logic [27:0]        y_top_o,
  output logic [27:0]        y_bottom_o,
  output logic signed [23:0] z_first_o,
  output logic signed [23:0] z_second_o,
  output logic signed [23:0] z_third_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic               lower_half_o
);

  localparam int CW = (MAX_ROW_LENGTH > 2) ? $clog2(MAX_ROW_LENGTH) : 1;
  localparam int RW = (MAX_ROW_COUNT > 2) ? $clog2(MAX_ROW_COUNT) : 1;
  localparam logic [16:0] LEN_MAX  = 17'(MAX_ROW_LENGTH);
  localparam logic [16:0] ROWS_MAX = 17'(MAX_ROW_COUNT);

  // configuration
  logic [10:0] row_len_q;
  logic [12:0] row_cnt_q;
  logic [15:0] cw_q, ch_q;
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;

  logic [16:0] len_c, rows_c;
  always_comb begin
    if (row_len_q < 11'd2)               len_c = 17'd2;
    else if (17'(row_len_q) > LEN_MAX)   len_c = LEN_MAX;
    else                                 len_c = 17'(row_len_q);
    if (row_cnt_q < 13'd2)               rows_c = 17'd2;
    else if (17'(row_cnt_q) > ROWS_MAX)  rows_c = ROWS_MAX;
    else                                 rows_c = 17'(row_cnt_q);
  end

  logic col_last, row_last;
  assign col_last = (17'(col_q) + 17'd1) >= len_c;
  assign row_last = (17'(row_q) + 17'd1) >= rows_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_len_q <= 11'd1024;
      row_cnt_q <= 13'd4096;
      cw_q      <= 16'd256;
      ch_q      <= 16'd256;
      col_q     <= '0;
      row_q     <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hfm_pkg::CFG_ROW_LENGTH: begin
          row_len_q <= cfg_data_i[10:0];
          col_q     <= '0;
          row_q     <= '0;
        end
        hfm_pkg::CFG_ROW_COUNT: begin
          row_cnt_q <= cfg_data_i[12:0];
          col_q     <= '0;
          row_q     <= '0;
        end
        hfm_pkg::CFG_CELL_WIDTH:  cw_q <= cfg_data_i;
        hfm_pkg::CFG_CELL_HEIGHT: ch_q <= cfg_data_i;
        default: ;
      endcase
    end else if (cmd_i.op == hfm_pkg::OP_LOAD) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_last ? '0 : RW'(row_q + RW'(1));
      end else begin
        col_q <= CW'(col_q + CW'(1));
      end
    end
  end

  // line store
  logic signed [23:0] mem [MAX_ROW_LENGTH];
  logic signed [23:0] up_q, z_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == hfm_pkg::OP_ACCEPT) begin
      up_q <= mem[col_q];
      z_q  <= height_i;
    end
    if (cmd_i.op == hfm_pkg::OP_LOAD) mem[col_q] <= z_q;
  end

  // neighbor samples
  logic signed [23:0] ul_q, lf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ul_q <= '0;
      lf_q <= '0;
    end else if (cmd_i.op == hfm_pkg::OP_LOAD) begin
      ul_q <= up_q;
      lf_q <= z_q;
    end
  end

  assign sts_o.has_result = (col_q != '0) && (row_q != '0);

  // cell corners and coordinates
  logic signed [23:0] zul_q, zur_q, zll_q, zlr_q;
  logic [25:0] xl_q, xr_q;
  logic [27:0] yt_q, yb_q;
  logic [CW-1:0]  col_m1;
  logic [CW+15:0] xl_p, xr_p;
  logic [16:0]    ydiff;
  logic [32:0]    yt_p, yb_p;

  assign col_m1 = CW'(col_q - CW'(1));
  assign xl_p   = (CW+16)'(col_m1) * (CW+16)'(cw_q);
  assign xr_p   = (CW+16)'(col_q) * (CW+16)'(cw_q);
  assign ydiff  = rows_c - 17'(row_q);
  assign yt_p   = 33'(ydiff) * 33'(ch_q);
  assign yb_p   = 33'(ydiff - 17'd1) * 33'(ch_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == hfm_pkg::OP_LOAD) begin
      zul_q <= ul_q;
      zur_q <= up_q;
      zll_q <= lf_q;
      zlr_q <= z_q;
      xl_q  <= 26'(xl_p);
      xr_q  <= 26'(xr_p);
      yt_q  <= 28'(yt_p);
      yb_q  <= 28'(yb_p);
    end
  end

  // cross product in sign and magnitude
  logic signed [24:0] d0, d1;
  logic [24:0] a0, a1;
  logic [40:0] p0, p1;
  logic [39:0] m0_q, m1_q;
  logic [31:0] m2_q;
  logic        s0_q, s1_q;

  always_comb begin
    if (cmd_i.half) begin
      d0 = 25'(zll_q) - 25'(zlr_q);
      d1 = 25'(zlr_q) - 25'(zur_q);
    end else begin
      d0 = 25'(zul_q) - 25'(zur_q);
      d1 = 25'(zll_q) - 25'(zul_q);
    end
    a0 = d0[24] ? (~d0 + 25'd1) : d0;
    a1 = d1[24] ? (~d1 + 25'd1) : d1;
  end

  assign p0 = 41'(ch_q) * 41'(a0);
  assign p1 = 41'(cw_q) * 41'(a1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == hfm_pkg::OP_CROSS) begin
      m0_q <= p0[39:0];
      m1_q <= p1[39:0];
      m2_q <= cw_q * ch_q;
      s0_q <= d0[24];
      s1_q <= d1[24];
    end
  end

  // sum of squares by partial products, then square root, then division
  logic [81:0] sum_q, sum_d;
  logic [81:0] res_q, res_d, bit_q, bit_d;
  logic [39:0] msel;
  logic [1:0]  part;
  logic [19:0] fa, fb;
  logic [39:0] prod;
  logic [81:0] term, res_cur, bit_cur, rt_t;

  always_comb begin
    msel = m0_q;
    part = 2'd0;
    unique case (cmd_i.step[3:0])
      4'd0: begin msel = m0_q;        part = 2'd0; end
      4'd1: begin msel = m0_q;        part = 2'd1; end
      4'd2: begin msel = m0_q;        part = 2'd2; end
      4'd3: begin msel = m1_q;        part = 2'd0; end
      4'd4: begin msel = m1_q;        part = 2'd1; end
      4'd5: begin msel = m1_q;        part = 2'd2; end
      4'd6: begin msel = 40'(m2_q);   part = 2'd0; end
      4'd7: begin msel = 40'(m2_q);   part = 2'd1; end
      4'd8: begin msel = 40'(m2_q);   part = 2'd2; end
      default: begin msel = m0_q;     part = 2'd0; end
    endcase
    fa = (part == 2'd0) ? msel[19:0] : msel[39:20];
    fb = (part == 2'd2) ? msel[39:20] : msel[19:0];
  end

  assign prod = fa * fb;

  always_comb begin
    unique case (part)
      2'd1:    term = 82'(prod) << 21;
      2'd2:    term = 82'(prod) << 40;
      default: term = 82'(prod);
    endcase
  end

  assign res_cur = (cmd_i.step == 6'd0) ? '0 : res_q;
  assign bit_cur = (cmd_i.step == 6'd0) ? hfm_pkg::RT_TOP : bit_q;
  assign rt_t    = res_cur + bit_cur;

  always_comb begin
    sum_d = sum_q;
    res_d = res_q;
    bit_d = bit_q;
    if (cmd_i.op == hfm_pkg::OP_SQ) begin
      sum_d = ((cmd_i.step == 6'd0) ? 82'd0 : sum_q) + term;
    end else if (cmd_i.op == hfm_pkg::OP_RT) begin
      bit_d = bit_cur >> 2;
      if (sum_q >= rt_t) begin
        sum_d = sum_q - rt_t;
        res_d = (res_cur >> 1) + bit_cur;
      end else begin
        res_d = res_cur >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    res_q <= res_d;
    bit_q <= bit_d;
  end

  logic [40:0] norm;
  logic [1:0]  comp;
  logic [41:0] rem_q, rem_cur, rem_d;
  logic [15:0] q_q, q_d;
  logic        ge, cneg;
  logic [15:0] nfin;
  logic [15:0] nx_q, ny_q, nz_q;
  logic [41:0] cmag;

  assign norm = res_q[40:0];
  assign comp = cmd_i.step[5:4];

  always_comb begin
    unique case (comp)
      2'd0:    begin cmag = 42'(m0_q); cneg = s0_q; end
      2'd1:    begin cmag = 42'(m1_q); cneg = s1_q; end
      default: begin cmag = 42'(m2_q); cneg = 1'b0; end
    endcase
    rem_cur = (cmd_i.step[3:0] == 4'd0) ? cmag : {rem_q[40:0], 1'b0};
    ge      = rem_cur >= 42'(norm);
    rem_d   = ge ? (rem_cur - 42'(norm)) : rem_cur;
    q_d     = (cmd_i.step[3:0] == 4'd0) ? 16'(ge) : {q_q[14:0], ge};
    nfin    = hfm_pkg::finish_comp(q_d, cneg, norm == '0);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == hfm_pkg::OP_DV) begin
      rem_q <= rem_d;
      q_q   <= q_d;
      if (cmd_i.step[3:0] == 4'hF) begin
        unique case (comp)
          2'd0:    nx_q <= nfin;
          2'd1:    ny_q <= nfin;
          default: nz_q <= nfin;
        endcase
      end
    end
  end

  // output register
  logic out_valid_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == hfm_pkg::OP_EMIT) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == hfm_pkg::OP_EMIT) begin
      x_left_o     <= xl_q;
      x_right_o    <= xr_q;
      y_top_o      <= yt_q;
      y_bottom_o   <= yb_q;
      z_first_o    <= cmd_i.half ? zlr_q : zul_q;
      z_second_o   <= cmd_i.half ? zur_q : zll_q;
      z_third_o    <= cmd_i.half ? zll_q : zur_q;
      normal_x_o   <= nx_q;
      normal_y_o   <= ny_q;
      normal_z_o   <= nz_q;
      lower_half_o <= cmd_i.half;
    end
  end

endmodule

// File: hdl/heightfield_triangle_mesher_core.sv
// Top level of the heightfield triangle mesher: controller plus datapath.
//
//   channel  direction  handshake                  payload
//   in       slave      in_valid_i / in_ready_o    height_i
//   out      master     out_valid_o / out_ready_i  x_left_o .. lower_half_o
//   cfg      slave      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// Each sample is accepted and loaded into the line store; one on the first
// row or first column ends there. A sample that closes a cell then takes,
// per triangle 1 cross product, 9 partial-product squares, 41 square-root
// steps, 48 restoring-division steps (16 per component) and 1 output load.
// Reset clears counters and sets the configuration to its defaults; the line store is not cleared.
// A stalled output beat holds; the second triangle waits for the first to
// leave, and the next sample is taken while the last beat still waits.
`timescale 1ns / 1ps
module heightfield_triangle_mesher_core #(
  parameter int MAX_ROW_LENGTH = 1024,
  parameter int MAX_ROW_COUNT  = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] height_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [25:0]        x_left_o,
  output logic [25:0]        x_right_o,
  output logic [27:0]        y_top_o,
  output logic [27:0]        y_bottom_o,
  output logic signed [23:0] z_first_o,
  output logic signed [23:0] z_second_o,
  output logic signed [23:0] z_third_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o,
  output logic               lower_half_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  hfm_pkg::cmd_t cmd;
  hfm_pkg::sts_t sts;

  // Configuration beats are always taken; the user must send them only while idle, the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  hfm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hfm_dp #(
    .MAX_ROW_LENGTH (MAX_ROW_LENGTH),
    .MAX_ROW_COUNT  (MAX_ROW_COUNT)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .height_i     (height_i),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .x_left_o     (x_left_o),
    .x_right_o    (x_right_o),
    .y_top_o      (y_top_o),
    .y_bottom_o   (y_bottom_o),
    .z_first_o    (z_first_o),
    .z_second_o   (z_second_o),
    .z_third_o    (z_third_o),
    .normal_x_o   (normal_x_o),
    .normal_y_o   (normal_y_o),
    .normal_z_o   (normal_z_o),
    .lower_half_o (lower_half_o)
  );

endmodule
